/* rtl/core/ppcs_pkg.sv */
// ----------------------------------------------------------------------------
// ppcs_pkg
// Shared types and constants of the ping-pong checkpoint store: field widths,
// operation and result codes, and the command and status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ppcs_pkg;

	// parameter defaults
	localparam int DEPTH_DEF     = 64;
	localparam int WORD_BITS_DEF = 32;

	// fixed field widths
	localparam int MODE_W     = 2;
	localparam int IDX_W      = 10;
	localparam int IN_VAL_W   = 32;
	localparam int KIND_W     = 2;
	localparam int EIDX_W     = 6;
	localparam int OUT_DATA_W = 32;
	localparam int SZ_W       = 7;

	// stream payload widths, padded to whole bytes
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_ENTRIES_IN_USE = 1'b0;
	localparam logic [SZ_W-1:0] ENTRIES_RESET = 7'd64;

	// reset fill byte of every stored word
	localparam logic [7:0] FILL_BYTE = 8'h53;

	// operation codes of an input beat
	typedef enum logic [MODE_W-1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_CKPT  = 2'd2
	} mode_t;

	// result codes of an output beat
	typedef enum logic [KIND_W-1:0] {
		KIND_READ = 2'd0,
		KIND_ACK  = 2'd1,
		KIND_SNAP = 2'd2
	} kind_t;

	// controller to datapath
	typedef struct packed {
		logic  ld_in;     // latch the accepted input beat
		logic  flip;      // toggle the active copy
		logic  clr_wr;    // clearing pass write and advance
		logic  mod_step;  // one remainder step
		logic  rd_walk;   // read address from the walk counter
		logic  op_wr;     // store write word into the active copy
		logic  ck_wr;     // checkpoint update of one entry
		logic  walk_inc;  // next checkpoint entry
		logic  out_ld;    // load the output register
		kind_t out_kind;  // kind of the loaded result
	} ppcs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic              clr_last;
		logic [MODE_W-1:0] in_mode;
		logic              in_rng;
		logic [MODE_W-1:0] item_mode;
		logic              mod_last;
		logic              walk_last;
		logic              out_free;
	} ppcs_sts_t;

endpackage

/* rtl/core/ping_pong_checkpoint_store.sv */
// ----------------------------------------------------------------------------
// ping_pong_checkpoint_store
// Word store kept in two copies with dirty bits and a snapshot. Reads and
// writes go to the active copy; a checkpoint flips the copy, folds the dirty
// entries of the old one into the snapshot and streams the snapshot out.
//
// channel   direction  handshake            payload
// s_*       in         tvalid/tready        tuser mode, tdata index/write_value
// m_*       out        tvalid/tready/tlast  tuser kind, tdata entry_index/data
// apb       in/out     psel/penable/pready  entries_in_use at address 0
//
// A read is accepted, reads the memory and then loads the output register; a
// write stores its word and loads its acknowledgement together. An index
// at or above the size in use first passes the bit-serial remainder unit.
// A checkpoint flips the copy at the accept, then for each entry in use does
// one memory read, then one update and load of the output register.
// After reset a clearing pass fills every entry of all memories; no input
// beat is accepted meanwhile, configuration writes are taken.
// A stalled output holds the controller before it loads the next result.
// ----------------------------------------------------------------------------
module ping_pong_checkpoint_store #(
	parameter int DEPTH     = ppcs_pkg::DEPTH_DEF,
	parameter int WORD_BITS = ppcs_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [9:0] index, [41:10] write_value, [47:42] zero
	input  logic [ppcs_pkg::S_TDATA_W-1:0]  s_tdata,
	// [1:0] mode
	input  logic [ppcs_pkg::MODE_W-1:0]     s_tuser,
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [5:0] entry_index, [37:6] data, [39:38] zero
	output logic [ppcs_pkg::M_TDATA_W-1:0]  m_tdata,
	// [1:0] kind
	output logic [ppcs_pkg::KIND_W-1:0]     m_tuser,
	output logic                            m_tlast,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ppcs_pkg::PADDR_W-1:0]    paddr,
	input  logic [ppcs_pkg::PDATA_W-1:0]    pwdata,
	output logic [ppcs_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import ppcs_pkg::*;

	ppcs_cmd_t       cmd;
	ppcs_sts_t       sts;
	logic [SZ_W-1:0] entries_in_use;

	ppcs_apb_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.entries_in_use (entries_in_use)
	);

	ppcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ppcs_datapath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.entries_in_use (entries_in_use),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast)
	);

endmodule

/* rtl/core/ppcs_apb_regs.sv */
// ----------------------------------------------------------------------------
// ppcs_apb_regs
// APB register file of the checkpoint store: holds the entries in use
// register and returns it on reads. pready is always high.
// ----------------------------------------------------------------------------
module ppcs_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppcs_pkg::PADDR_W-1:0]  paddr,
	input  logic [ppcs_pkg::PDATA_W-1:0]  pwdata,
	output logic [ppcs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output logic [ppcs_pkg::SZ_W-1:0]     entries_in_use
);
	import ppcs_pkg::*;

	logic               wr_en;
	logic [SZ_W-1:0]    entries_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register write at the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (wr_en && (paddr[2] == REG_ENTRIES_IN_USE)) begin
			entries_q <= pwdata[SZ_W-1:0];
		end
	end

	// read back
	always_comb begin
		if (paddr[2] == REG_ENTRIES_IN_USE) begin
			prdata = PDATA_W'(entries_q);
		end else begin
			prdata = '0;
		end
	end

	assign entries_in_use = entries_q;

endmodule

/* rtl/core/ppcs_ctrl.sv */
// ----------------------------------------------------------------------------
// ppcs_ctrl
// Controller of the checkpoint store: clearing pass after reset, index wrap
// steps, read and write access, and the checkpoint walk over entries in use.
// ----------------------------------------------------------------------------
module ppcs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  ppcs_pkg::ppcs_sts_t  sts,
	output ppcs_pkg::ppcs_cmd_t  cmd
);
	import ppcs_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_RD,
		ST_LOAD,
		ST_WR,
		ST_CK_RD,
		ST_CK_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_fire;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.out_kind = KIND_READ;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire) begin
					cmd.ld_in = 1'b1;
					unique case (sts.in_mode)
						MODE_READ:  state_d = sts.in_rng ? ST_RD : ST_MOD;
						MODE_WRITE: state_d = sts.in_rng ? ST_WR : ST_MOD;
						MODE_CKPT: begin
							cmd.flip = 1'b1;
							state_d  = ST_CK_RD;
						end
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = (sts.item_mode == MODE_WRITE) ? ST_WR : ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_kind = KIND_READ;
					state_d      = ST_IDLE;
				end
			end
			ST_WR: begin
				if (sts.out_free) begin
					cmd.op_wr    = 1'b1;
					cmd.out_ld   = 1'b1;
					cmd.out_kind = KIND_ACK;
					state_d      = ST_IDLE;
				end
			end
			ST_CK_RD: begin
				cmd.rd_walk = 1'b1;
				state_d     = ST_CK_OUT;
			end
			ST_CK_OUT: begin
				cmd.rd_walk = 1'b1;
				if (sts.out_free) begin
					cmd.ck_wr    = 1'b1;
					cmd.out_ld   = 1'b1;
					cmd.out_kind = KIND_SNAP;
					if (sts.walk_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.walk_inc = 1'b1;
						state_d      = ST_CK_RD;
					end
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// an item that does work closes the input until it is done
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (sts.in_mode == MODE_READ || sts.in_mode == MODE_WRITE ||
		 sts.in_mode == MODE_CKPT)) |=> !s_tready)
		else $error("input ready while an item is at work");

endmodule

/* rtl/core/ppcs_datapath.sv */
// ----------------------------------------------------------------------------
// ppcs_datapath
// Datapath of the checkpoint store: the two copies, the dirty bits and the
// snapshot as memories, the serial index wrap unit, the walk and clearing
// counters, and the output register.
// ----------------------------------------------------------------------------
module ppcs_datapath #(
	parameter int DEPTH     = ppcs_pkg::DEPTH_DEF,
	parameter int WORD_BITS = ppcs_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ppcs_pkg::ppcs_cmd_t             cmd,
	output ppcs_pkg::ppcs_sts_t             sts,
	input  logic [ppcs_pkg::SZ_W-1:0]       entries_in_use,
	input  logic [ppcs_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [ppcs_pkg::MODE_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ppcs_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [ppcs_pkg::KIND_W-1:0]     m_tuser,
	output logic                            m_tlast
);
	import ppcs_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int DCAP  = (DEPTH < 127) ? DEPTH : 127;
	localparam int CNT_W = $clog2(IDX_W);
	localparam logic [WORD_BITS-1:0] FILL_WORD = WORD_BITS'({8{FILL_BYTE}});

	// input fields
	logic [IDX_W-1:0]    s_index;
	logic [IN_VAL_W-1:0] s_wval;

	// item registers
	logic [MODE_W-1:0]    mode_q;
	logic [IDX_W-1:0]     qsh_q;
	logic [SZ_W-1:0]      rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] wval_q;
	logic [SZ_W-1:0]      walk_q;
	logic [AW-1:0]        clr_q;
	logic                 active_q;

	// memories and their registered reads
	logic [WORD_BITS-1:0] copy0_mem [DEPTH];
	logic [WORD_BITS-1:0] copy1_mem [DEPTH];
	logic [WORD_BITS-1:0] snap_mem  [DEPTH];
	logic                 dirty0_mem [DEPTH];
	logic                 dirty1_mem [DEPTH];
	logic [WORD_BITS-1:0] c0_rd_q;
	logic [WORD_BITS-1:0] c1_rd_q;
	logic [WORD_BITS-1:0] sn_rd_q;
	logic                 d0_rd_q;
	logic                 d1_rd_q;

	// output register
	logic                  out_valid_q;
	logic [KIND_W-1:0]     out_kind_q;
	logic [EIDX_W-1:0]     out_eidx_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	logic [SZ_W-1:0]      n_sz;
	logic                 in_rng;
	logic [SZ_W:0]        mod_r;
	logic                 walk_last;
	logic                 dsel;
	logic [AW-1:0]        idx_addr;
	logic [AW-1:0]        walk_addr;
	logic [AW-1:0]        raddr;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] ck_src;
	logic                 ck_dirty;
	logic [WORD_BITS-1:0] ck_word;

	logic                 c0_we, c1_we, sn_we, d0_we, d1_we;
	logic [AW-1:0]        cp_wa, sn_wa, d_wa;
	logic [WORD_BITS-1:0] cp_wd, sn_wd;
	logic                 d_wd;

	assign s_index = s_tdata[IDX_W-1:0];
	assign s_wval  = s_tdata[IDX_W +: IN_VAL_W];

	// size in use, clamped to one and to the depth (at most 127)
	always_comb begin
		priority if (entries_in_use == '0) begin
			n_sz = SZ_W'(1);
		end else if (int'(entries_in_use) > DCAP) begin
			n_sz = SZ_W'(DCAP);
		end else begin
			n_sz = entries_in_use;
		end
	end

	assign in_rng    = (s_index < IDX_W'(n_sz));
	assign mod_r     = {rem_q, qsh_q[IDX_W-1]};
	assign walk_last = (walk_q == n_sz - SZ_W'(1));

	// item capture and restoring remainder, one index bit per step
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			mode_q <= s_tuser;
			qsh_q  <= s_index;
			rem_q  <= in_rng ? s_index[SZ_W-1:0] : '0;
			wval_q <= WORD_BITS'(s_wval);
		end else if (cmd.mod_step) begin
			qsh_q <= qsh_q << 1;
			if (mod_r >= {1'b0, n_sz}) begin
				rem_q <= SZ_W'(mod_r - {1'b0, n_sz});
			end else begin
				rem_q <= mod_r[SZ_W-1:0];
			end
		end
	end

	// control counters and active copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			walk_q   <= '0;
			clr_q    <= '0;
			active_q <= 1'b0;
		end else begin
			if (cmd.ld_in) begin
				cnt_q  <= '0;
				walk_q <= '0;
			end else begin
				if (cmd.mod_step) cnt_q <= cnt_q + CNT_W'(1);
				if (cmd.walk_inc) walk_q <= walk_q + SZ_W'(1);
			end
			if (cmd.flip) active_q <= ~active_q;
			if (cmd.clr_wr) clr_q <= clr_q + AW'(1);
		end
	end

	// addresses and write ports
	assign dsel      = ~active_q;
	assign idx_addr  = AW'(rem_q);
	assign walk_addr = AW'(walk_q);
	assign raddr     = cmd.rd_walk ? walk_addr : idx_addr;

	assign c0_we = cmd.clr_wr || (cmd.op_wr && !active_q);
	assign c1_we = cmd.clr_wr || (cmd.op_wr && active_q);
	assign cp_wa = cmd.clr_wr ? clr_q : idx_addr;
	assign cp_wd = cmd.clr_wr ? FILL_WORD : wval_q;

	assign d0_we = cmd.clr_wr || (cmd.op_wr && !active_q) || (cmd.ck_wr && !dsel);
	assign d1_we = cmd.clr_wr || (cmd.op_wr && active_q) || (cmd.ck_wr && dsel);
	assign d_wa  = cmd.clr_wr ? clr_q : (cmd.ck_wr ? walk_addr : idx_addr);
	assign d_wd  = cmd.op_wr;

	assign sn_we = cmd.clr_wr || cmd.ck_wr;
	assign sn_wa = cmd.clr_wr ? clr_q : walk_addr;
	assign sn_wd = cmd.clr_wr ? FILL_WORD : ck_word;

	// read word and merged checkpoint word
	assign rd_word  = active_q ? c1_rd_q : c0_rd_q;
	assign ck_src   = dsel ? c1_rd_q : c0_rd_q;
	assign ck_dirty = dsel ? d1_rd_q : d0_rd_q;
	assign ck_word  = ck_dirty ? ck_src : sn_rd_q;

	// copy memories
	always_ff @(posedge clk) begin
		if (c0_we) copy0_mem[cp_wa] <= cp_wd;
		c0_rd_q <= copy0_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (c1_we) copy1_mem[cp_wa] <= cp_wd;
		c1_rd_q <= copy1_mem[raddr];
	end

	// snapshot memory
	always_ff @(posedge clk) begin
		if (sn_we) snap_mem[sn_wa] <= sn_wd;
		sn_rd_q <= snap_mem[raddr];
	end

	// dirty bit memories
	always_ff @(posedge clk) begin
		if (d0_we) dirty0_mem[d_wa] <= d_wd;
		d0_rd_q <= dirty0_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (d1_we) dirty1_mem[d_wa] <= d_wd;
		d1_rd_q <= dirty1_mem[raddr];
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_kind_q <= cmd.out_kind;
			unique case (cmd.out_kind)
				KIND_READ: begin
					out_eidx_q <= rem_q[EIDX_W-1:0];
					out_data_q <= OUT_DATA_W'(rd_word);
					out_last_q <= 1'b1;
				end
				KIND_SNAP: begin
					out_eidx_q <= walk_q[EIDX_W-1:0];
					out_data_q <= OUT_DATA_W'(ck_word);
					out_last_q <= walk_last;
				end
				default: begin
					out_eidx_q <= rem_q[EIDX_W-1:0];
					out_data_q <= '0;
					out_last_q <= 1'b1;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({out_data_q, out_eidx_q});
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	// status
	assign sts.clr_last  = (clr_q == AW'(DEPTH - 1));
	assign sts.in_mode   = s_tuser;
	assign sts.in_rng    = in_rng;
	assign sts.item_mode = mode_q;
	assign sts.mod_last  = (cnt_q == CNT_W'(IDX_W - 1));
	assign sts.walk_last = walk_last;
	assign sts.out_free  = !out_valid_q || m_tready;

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || m_tready))
		else $error("output register loaded while a beat is pending");

	// the wrapped index is below the size in use when it is reported
	a_idx_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_ld && cmd.out_kind != KIND_SNAP) |-> (rem_q < n_sz))
		else $error("wrapped index not below size in use");

	// the checkpoint walk stays within the entries in use
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_ld && cmd.out_kind == KIND_SNAP) |-> (walk_q < n_sz))
		else $error("checkpoint walk beyond entries in use");

	// the walk only advances before its final entry
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_inc |-> !walk_last)
		else $error("checkpoint walk advanced past its final entry");

endmodule

/* dv/ping_pong_checkpoint_store_tb.sv */
// ----------------------------------------------------------------------------
// ping_pong_checkpoint_store_tb
// Self-checking bench for the ping-pong checkpoint store. A scoreboard class
// keeps its own model of both copies, the dirty bits and the snapshot, and
// compares every output beat with the oldest predicted one. A directed
// opener covers the index extremes, the wrap, the unused mode and copy flips.
// Random phases then follow, each with its own store size and handshake
// pressure on both streams.
// ----------------------------------------------------------------------------
module ping_pong_checkpoint_store_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ppcs_pkg::*;

	localparam int DEPTH  = DEPTH_DEF;
	localparam int WORD_W = WORD_BITS_DEF;

	// mode 3 has no operation and must give no beat
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] SIZE_ADDR = PADDR_W'({REG_ENTRIES_IN_USE, 2'b00});

	// quiet cycles allowed before the run is declared hung
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	// cycles allowed for a wrapped read to settle after the last beat
	localparam int unsigned SETTLE_CYCLES = 24;

	// random phases: size written, sender idle and receiver stall percentages
	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 42;
	localparam int unsigned PHASE_SIZE [NUM_PHASES] = '{1, 0, 127, 65, 7, 13, 0, 64};
	localparam int unsigned PHASE_SEND [NUM_PHASES] = '{0, 72, 0, 30, 0, 72, 0, 30};
	localparam int unsigned PHASE_STALL [NUM_PHASES] = '{0, 0, 72, 30, 0, 0, 72, 30};
	localparam int RANDOM_SIZE_PHASE = 6;

	typedef struct {
		kind_t              kind;
		logic [EIDX_W-1:0]  eidx;
		logic [WORD_W-1:0]  data;
		logic               last;
	} result_beat_t;

	// predicts the store and checks output beats in order
	class ckpt_scoreboard;
		logic [WORD_W-1:0] copy_words [2][DEPTH];
		logic [WORD_W-1:0] snap_words [DEPTH];
		logic [DEPTH-1:0]  dirty_bits [2];
		bit                active;
		logic [SZ_W-1:0]   entries_in_use;
		result_beat_t      expected_beats [$];
		int                errors;

		function new();
			for (int i = 0; i < DEPTH; i++) begin
				copy_words[0][i] = {(WORD_W/8){FILL_BYTE}};
				copy_words[1][i] = {(WORD_W/8){FILL_BYTE}};
				snap_words[i]    = {(WORD_W/8){FILL_BYTE}};
			end
			dirty_bits[0]  = '0;
			dirty_bits[1]  = '0;
			active         = 1'b0;
			entries_in_use = ENTRIES_RESET;
			errors         = 0;
		endfunction

		// zero acts as one, anything above the depth as the depth
		function int unsigned live_size();
			if (entries_in_use == 0)
				return 1;
			if (entries_in_use > DEPTH)
				return DEPTH;
			return entries_in_use;
		endfunction

		task report(input string msg);
			errors++;
			$display("%0t: %s", $time, msg);
		endtask

		// update the model for one accepted input beat and queue its results
		function void apply_command(input logic [MODE_W-1:0] mode,
				input logic [IDX_W-1:0] idx_in, input logic [IN_VAL_W-1:0] wval);
			int unsigned  n;
			int unsigned  slot;
			bit           old_copy;
			result_beat_t r;
			n    = live_size();
			slot = idx_in % n;
			case (mode)
				MODE_READ: begin
					r.kind = KIND_READ;
					r.eidx = EIDX_W'(slot);
					r.data = copy_words[active][slot];
					r.last = 1'b1;
					expected_beats.push_back(r);
				end
				MODE_WRITE: begin
					copy_words[active][slot] = wval[WORD_W-1:0];
					dirty_bits[active][slot] = 1'b1;
					r.kind = KIND_ACK;
					r.eidx = EIDX_W'(slot);
					r.data = '0;
					r.last = 1'b1;
					expected_beats.push_back(r);
				end
				MODE_CKPT: begin
					// flip, fold the old copy's dirty entries, stream the snapshot
					old_copy = active;
					active   = ~active;
					for (int i = 0; i < n; i++) begin
						if (dirty_bits[old_copy][i]) begin
							snap_words[i] = copy_words[old_copy][i];
							dirty_bits[old_copy][i] = 1'b0;
						end
					end
					for (int i = 0; i < n; i++) begin
						r.kind = KIND_SNAP;
						r.eidx = EIDX_W'(i);
						r.data = snap_words[i];
						r.last = (i + 1 == n);
						expected_beats.push_back(r);
					end
				end
				default: ;
			endcase
		endfunction

		// compare one output beat field by field with the oldest prediction
		task check_beat(input logic [KIND_W-1:0] kind, input logic [EIDX_W-1:0] eidx,
				input logic [WORD_W-1:0] data, input logic last);
			result_beat_t want;
			if (expected_beats.size() == 0) begin
				report($sformatf("unexpected beat kind %0d idx %0d data %h last %b",
					kind, eidx, data, last));
				return;
			end
			want = expected_beats.pop_front();
			if (kind !== want.kind)
				report($sformatf("kind %0d, want %0d (idx %0d)", kind, want.kind, want.eidx));
			if (eidx !== want.eidx)
				report($sformatf("entry_index %0d, want %0d", eidx, want.eidx));
			if (data !== want.data)
				report($sformatf("data %h, want %h (idx %0d)", data, want.data, want.eidx));
			if (last !== want.last)
				report($sformatf("last %b, want %b (idx %0d)", last, want.last, want.eidx));
		endtask
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// [9:0] index, [41:10] write_value, [47:42] zero
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	// [1:0] mode
	logic [MODE_W-1:0]     s_tuser  = MODE_READ;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [5:0] entry_index, [37:6] data, [39:38] zero
	logic [M_TDATA_W-1:0]  m_tdata;
	// [1:0] kind
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [PADDR_W-1:0]    paddr    = '0;
	logic [PDATA_W-1:0]    pwdata   = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;

	ckpt_scoreboard sb = new();

	ping_pong_checkpoint_store u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// receiver backpressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// beat monitor on both streams
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.apply_command(s_tuser, s_tdata[IDX_W-1:0], s_tdata[IDX_W +: IN_VAL_W]);
		if (m_tvalid && m_tready)
			sb.check_beat(m_tuser, m_tdata[EIDX_W-1:0], m_tdata[EIDX_W +: OUT_DATA_W],
				m_tlast);
	end

	// hang detection: cycles with no beat on either stream
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	// one input beat after a random idle gap; returns at the falling edge
	task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx,
			input logic [IN_VAL_W-1:0] wval);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= m;
		s_tdata  <= {{(S_TDATA_W-IDX_W-IN_VAL_W){1'b0}}, wval, idx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// hold the input until every predicted beat has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.expected_beats.size() != 0);
	endtask

	// write the size register, then read it back
	task automatic set_entries(input logic [SZ_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SIZE_ADDR;
		pwdata  <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.entries_in_use = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(value))
			sb.report($sformatf("entries_in_use reads %h, want %h", prdata, value));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int unsigned          n;
		int unsigned          pick;
		logic [MODE_W-1:0]    m;
		logic [IDX_W-1:0]     idx;
		logic [SZ_W-1:0]      sz;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// taken during the clearing pass
		set_entries(ENTRIES_RESET);

		// directed opener at full size, no idling
		send_cmd(MODE_READ, 10'd0, '0);
		send_cmd(MODE_READ, 10'd1023, '0);
		send_cmd(MODE_WRITE, 10'd0, 32'h0000_0000);
		send_cmd(MODE_WRITE, 10'd63, 32'hFFFF_FFFF);
		send_cmd(MODE_WRITE, 10'd1023, 32'hA5A5_A5A5);
		send_cmd(MODE_READ, 10'd63, '0);
		send_cmd(MODE_READ, 10'd64, '0);
		send_cmd(MODE_UNUSED, 10'd5, 32'hDEAD_BEEF);
		send_cmd(MODE_READ, 10'd5, '0);
		send_cmd(MODE_WRITE, 10'h2AA, 32'h5A5A_5A5A);
		send_cmd(MODE_WRITE, 10'h155, 32'h1234_5678);
		wait_drained();
		send_cmd(MODE_CKPT, 10'd0, '0);
		send_cmd(MODE_READ, 10'd0, '0);
		send_cmd(MODE_WRITE, 10'd0, 32'hCAFE_F00D);
		send_cmd(MODE_CKPT, 10'd1023, 32'hFFFF_FFFF);
		send_cmd(MODE_READ, 10'd0, '0);
		send_cmd(MODE_CKPT, 10'd0, '0);
		send_cmd(MODE_READ, 10'd1022, '0);

		// random phases, size changed only when the store is idle
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			send_idle_pct = 0;
			stall_pct     = 0;
			repeat (SETTLE_CYCLES) @(negedge clk);
			sz = (ph == RANDOM_SIZE_PHASE) ? SZ_W'($urandom_range(2, DEPTH - 1))
				: SZ_W'(PHASE_SIZE[ph]);
			set_entries(sz);
			send_idle_pct = PHASE_SEND[ph];
			stall_pct     = PHASE_STALL[ph];
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				n = sb.live_size();
				if ($urandom_range(39) == 0)
					wait_drained();
				pick = $urandom_range(99);
				if (pick < 3)
					m = MODE_UNUSED;
				else if (pick < 11)
					m = MODE_CKPT;
				else if (pick < 55)
					m = MODE_WRITE;
				else
					m = MODE_READ;
				// mostly in range so writes and reads meet, some wrapped
				if ($urandom_range(9) < 7)
					idx = IDX_W'($urandom_range(n - 1));
				else
					idx = IDX_W'($urandom_range(1023));
				send_cmd(m, idx, $urandom());
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.expected_beats.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
